@@ hdl/assert_macros.svh @@
// assertion macros for the rtl of the fletcher-32 block, included by fl32_accum
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define FL32_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("fl32 assertion failed");

// condition must never be seen at a clock edge outside reset
`define FL32_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("fl32 forbidden condition");

`else

`define FL32_ASSERT(lbl, clk, rst_n, prop)
`define FL32_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ hdl/fl32_pkg.sv @@
// types, constants and the 16-bit fold for the fletcher-32 block
// no dependencies
package fl32_pkg;

    localparam int unsigned SUM_W   = 32;
    localparam int unsigned HALF_W  = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CNT_W   = 9;

    localparam logic [SUM_W-1:0] START_SUM   = 32'h0000_ffff;
    localparam logic [CNT_W-1:0] BLOCK_WORDS = 9'd360;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_item;

    typedef struct packed {
        logic [SUM_W-1:0] second_sum;
        logic [SUM_W-1:0] first_sum;
    } t_sums;

    // low half plus high half
    function automatic logic [SUM_W-1:0] fold16(input logic [SUM_W-1:0] x);
        fold16 = {{HALF_W{1'b0}}, x[HALF_W-1:0]} + {{HALF_W{1'b0}}, x[SUM_W-1:HALF_W]};
    endfunction

endpackage

@@ hdl/fl32_if.sv @@
// valid/ready channel interfaces of the fletcher-32 block
// depends on fl32_pkg for the field widths
interface fl32_byte_if;
    logic                      valid;
    logic                      ready;
    logic [fl32_pkg::BYTE_W-1:0] data_byte;
    logic                      last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fl32_sum_if;
    logic                       valid;
    logic                       ready;
    logic [fl32_pkg::SUM_W-1:0] checksum;

    modport source (output valid, output checksum, input ready);
    modport sink   (input valid, input checksum, output ready);
endinterface

@@ hdl/fl32_accum.sv @@
// running sums, block counter and byte phase of the fletcher-32 block
// depends on fl32_pkg and assert_macros.svh
`include "assert_macros.svh"

module fl32_accum (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  fl32_pkg::t_item i_item,
    output fl32_pkg::t_sums o_sums
);
    import fl32_pkg::*;

    logic [SUM_W-1:0] r_s1;
    logic [SUM_W-1:0] r_s2;
    logic [CNT_W-1:0] r_cnt;
    logic             r_hi;
    logic             r_fp;

    logic             do_fold;
    logic [SUM_W-1:0] base1;
    logic [SUM_W-1:0] base2;
    logic [SUM_W-1:0] addend;
    logic [SUM_W-1:0] sum1;
    logic [SUM_W-1:0] sum2;
    logic [SUM_W-1:0] n_s2;
    logic [CNT_W-1:0] cnt_inc;
    logic             wrap;
    logic             at_start;

    always_comb begin
        // pending block fold goes ahead of a low byte, except a trailing odd byte
        do_fold = r_fp && !r_hi && !i_item.last_byte;
        base1   = do_fold ? fold16(r_s1) : r_s1;
        base2   = do_fold ? fold16(r_s2) : r_s2;
        addend  = r_hi ? {{(SUM_W-HALF_W){1'b0}}, i_item.data_byte, {BYTE_W{1'b0}}}
                       : {{(SUM_W-BYTE_W){1'b0}}, i_item.data_byte};
        sum1    = base1 + addend;
        sum2    = base2 + sum1;
        n_s2    = (r_hi || i_item.last_byte) ? sum2 : base2;
        cnt_inc = r_cnt + 1'b1;
        wrap    = r_hi && (cnt_inc == BLOCK_WORDS);
    end

    assign o_sums = '{second_sum: sum2, first_sum: sum1};

    // sums and counters back at their start values
    assign at_start = (r_s1 == START_SUM) && (r_s2 == START_SUM) && !r_hi && (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.last_byte)) begin
            r_s1  <= START_SUM;
            r_s2  <= START_SUM;
            r_cnt <= '0;
            r_hi  <= 1'b0;
            r_fp  <= 1'b0;
        end else if (i_step) begin
            r_s1 <= sum1;
            r_s2 <= n_s2;
            r_hi <= !r_hi;
            r_fp <= wrap;
            if (r_hi) begin
                r_cnt <= wrap ? '0 : cnt_inc;
            end
        end
    end

    `FL32_NEVER(a_no_fold_on_high, i_clk, i_rst_n, r_hi && r_fp)
    `FL32_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt < BLOCK_WORDS)
    `FL32_ASSERT(a_restart, i_clk, i_rst_n, (i_step && i_item.last_byte) |=> at_start)
    `FL32_ASSERT(a_fold_only_at_wrap, i_clk, i_rst_n, $rose(r_fp) |-> ($past(r_hi) && r_cnt == '0))

endmodule

@@ hdl/fletcher32_odd_length_checksum_top.sv @@
// top level of the streaming fletcher-32 checksum with odd-length handling
// depends on fl32_pkg, fl32_if and fl32_accum
//
// usage
//   i_in carries one message byte per request, data_byte plus last_byte, which
//   marks the final byte of a message. bytes pair up as little-endian 16-bit
//   words; a trailing odd byte counts as a low byte. sums fold every 360 words.
//   o_out carries one request per message: checksum = second sum in bits 31:16,
//   first sum in bits 15:0, taken when the final byte is accepted.
// throughput and pipeline
//   one byte per clock is sustained while no final byte waits on a stalled
//   o_out. a byte sits in the input register, then updates the running sums
//   or, if final, has its sums captured in the pre-fold register; the final
//   fold is done on the way into the output register, which drives o_out.
// reset
//   i_rst_n low at a rising edge clears all stages and restarts the sums at
//   0xffff; after each message the sums restart on their own.
// stall
//   a stalled o_out holds its checksum; one more finished message waits in the
//   pre-fold register, and bytes keep flowing until a further final byte needs
//   that slot, then i_in.ready drops.

module fletcher32_odd_length_checksum_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fl32_byte_if.sink  i_in,
    fl32_sum_if.source o_out
);
    import fl32_pkg::*;

    // input register stage
    logic  r_in_vld;
    t_item r_in;
    // finished sums before the final fold
    logic  r_fin_vld;
    t_sums r_fin;
    // output register
    logic             r_out_vld;
    logic [SUM_W-1:0] r_out_sum;

    logic             out_free;
    logic             fin_move;
    logic             fin_free;
    logic             in_step;
    logic             in_free;
    logic [SUM_W-1:0] f1;
    logic [SUM_W-1:0] f2;
    t_sums            sums;

    // ready chain: a stage may load when it is empty or empties this cycle
    assign out_free = !r_out_vld || o_out.ready;
    assign fin_move = r_fin_vld && out_free;
    assign fin_free = !r_fin_vld || fin_move;
    // non-final bytes only touch the running sums and never wait
    assign in_step  = r_in_vld && (!r_in.last_byte || fin_free);
    assign in_free  = !r_in_vld || in_step;

    assign i_in.ready     = in_free;
    assign o_out.valid    = r_out_vld;
    assign o_out.checksum = r_out_sum;

    fl32_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (in_step),
        .i_item  (r_in),
        .o_sums  (sums)
    );

    // final fold, applied twice, leaves each sum within 16 bits
    always_comb begin
        f1 = fold16(fold16(r_fin.first_sum));
        f2 = fold16(fold16(r_fin.second_sum));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_fin_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_free) begin
                r_in_vld <= i_in.valid;
            end
            if (fin_free) begin
                r_fin_vld <= in_step && r_in.last_byte;
            end
            if (out_free) begin
                r_out_vld <= r_fin_vld;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_free && i_in.valid) begin
            r_in <= '{data_byte: i_in.data_byte, last_byte: i_in.last_byte};
        end
        if (in_step && r_in.last_byte) begin
            r_fin <= sums;
        end
        if (fin_move) begin
            r_out_sum <= {f2[HALF_W-1:0], f1[HALF_W-1:0]};
        end
    end

endmodule
